// ===== rtl/free_bitmap_allocator_macros.svh =====
// Assertion macros for the free bitmap allocator RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef FREE_BITMAP_ALLOCATOR_MACROS_SVH
`define FREE_BITMAP_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define FBA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("free_bitmap_allocator assertion failed");
`define FBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("free_bitmap_allocator assertion failed");
`else
`define FBA_ASSERT(lbl, clk, rst_n, prop)
`define FBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/fba_pkg.sv =====
// Shared types and constants of the free bitmap allocator.
// No dependencies; used by the top level and fba_word_eval.
`timescale 1ns / 1ps
package fba_pkg;

    localparam int WORD_BITS = 64;
    localparam int LSB_BITS = 6;
    localparam int BYTE_BITS = 8;
    localparam int BYTES_PER_WORD = 8;
    localparam int CFG_BITS = 13;
    localparam int IDX_BITS = 12;
    localparam int CNT_BITS = 13;
    localparam int IN_BITS = 16;
    localparam int OUT_BITS = 32;
    localparam logic [CFG_BITS-1:0] BITS_IN_USE_RESET = 13'd4096;

    typedef enum logic [2:0] {
        OP_SET        = 3'd0,
        OP_CLEAR      = 3'd1,
        OP_TEST       = 3'd2,
        OP_FIND_FREE  = 3'd3,
        OP_FIND_SET   = 3'd4,
        OP_COUNT_FREE = 3'd5,
        OP_COUNT_SET  = 3'd6,
        OP_NONE       = 3'd7
    } t_op;

    typedef struct packed {
        logic       hit;
        logic [5:0] lsb;
        logic [6:0] ones;
    } t_eval;

endpackage

// ===== rtl/free_bitmap_allocator.sv =====
// Free bitmap allocator top level: request sequencer around the word store.
// Depends on fba_pkg, fba_mem, fba_word_eval and the assertion macro header.
//
// The bitmap sits in a single-port-read store of 64-bit words, one bit per block,
// with bit i in word i/64. After reset a clearing pass writes every word to zero,
// one word per cycle; no request is accepted during that pass, while writes of
// bits_in_use are taken at all times. A set, clear or test goes from acceptance
// through a read, a modify and write back, and a result step that loads the output
// register. A find or count walks the first ceil(L/64) words one word per cycle
// through the read port, where L is bits_in_use limited to CAPACITY_BITS; a find
// ends at the first word holding a match, and with L of zero no word is read and
// the request goes straight to the result step. One request is worked at a time;
// the finished result waits in the output register while the next request is
// accepted.
`timescale 1ns / 1ps
`include "free_bitmap_allocator_macros.svh"
module free_bitmap_allocator #(
    parameter int CAPACITY_BITS = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fba_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [2:0] operation, [14:3] bit_index, [15] zero
    input  logic [fba_pkg::IN_BITS-1:0]   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] bit_value, [1] found, [13:2] position, [26:14] bit_count, [31:27] zero
    output logic [fba_pkg::OUT_BITS-1:0]  m_axis_tdata
);

    localparam int WB = fba_pkg::WORD_BITS;
    localparam int LB = fba_pkg::LSB_BITS;
    localparam int DEPTH = (CAPACITY_BITS + WB - 1) / WB;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(CAPACITY_BITS + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                         r_state;
    logic [AW-1:0]                  r_clr_ptr;
    fba_pkg::t_op                   r_op;
    logic [AW-1:0]                  r_word;
    logic [LB-1:0]                  r_bit;
    logic                           r_range;
    logic [AW-1:0]                  r_proc;
    logic [AW-1:0]                  r_last;
    logic [WB-1:0]                  r_last_mask;
    logic [CW-1:0]                  r_lim;
    logic                           r_want;
    logic                           r_bv;
    logic                           r_found;
    logic [fba_pkg::IDX_BITS-1:0]   r_pos;
    logic [CW-1:0]                  r_cnt;
    logic                           r_out_valid;
    logic [fba_pkg::OUT_BITS-1:0]   r_out_data;
    logic [fba_pkg::CFG_BITS-1:0]   r_bits;

    logic                           s_acc;
    logic                           m_acc;
    fba_pkg::t_op                   in_op;
    logic [fba_pkg::IDX_BITS-1:0]   in_idx;
    logic                           in_range;
    logic [AW-1:0]                  in_word;
    logic                           in_scan;
    logic [31:0]                    lim32;
    logic [31:0]                    lim_m1;
    logic [AW-1:0]                  last_word;
    logic [WB-1:0]                  last_mask;
    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [WB-1:0]                  mem_wdata;
    logic [AW-1:0]                  mem_raddr;
    logic [WB-1:0]                  mem_rdata;
    logic [WB-1:0]                  eval_mask;
    fba_pkg::t_eval                 ev;
    logic                           is_find;
    logic [AW+LB-1:0]               hit_pos;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out_data;
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = r_out_valid && m_axis_tready;

    assign in_op = fba_pkg::t_op'(s_axis_tdata[2:0]);
    assign in_idx = s_axis_tdata[14:3];
    assign in_range = 32'(in_idx) < 32'(CAPACITY_BITS);
    assign in_word = AW'(32'(in_idx) >> LB);
    assign in_scan = (in_op == fba_pkg::OP_FIND_FREE) || (in_op == fba_pkg::OP_FIND_SET) ||
                     (in_op == fba_pkg::OP_COUNT_FREE) || (in_op == fba_pkg::OP_COUNT_SET);

    assign lim32 = (32'(r_bits) > 32'(CAPACITY_BITS)) ? 32'(CAPACITY_BITS) : 32'(r_bits);
    assign lim_m1 = lim32 - 32'd1;
    assign last_word = AW'(lim_m1 >> LB);
    assign last_mask = {WB{1'b1}} >> (32'(WB - 1) - 32'(lim_m1[LB-1:0]));

    assign is_find = (r_op == fba_pkg::OP_FIND_FREE) || (r_op == fba_pkg::OP_FIND_SET);
    assign eval_mask = (r_proc == r_last) ? r_last_mask : {WB{1'b1}};
    assign hit_pos = {r_proc, ev.lsb};

    always_comb begin
        mem_we = 1'b0;
        mem_waddr = r_word;
        mem_wdata = mem_rdata;
        mem_raddr = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_waddr = r_clr_ptr;
                mem_wdata = '0;
            end
            S_IDLE: begin
                mem_raddr = in_scan ? '0 : in_word;
            end
            S_MOD: begin
                mem_we = r_range &&
                         ((r_op == fba_pkg::OP_SET) || (r_op == fba_pkg::OP_CLEAR));
                mem_wdata = (r_op == fba_pkg::OP_SET) ?
                            (mem_rdata | (WB'(1) << r_bit)) :
                            (mem_rdata & ~(WB'(1) << r_bit));
            end
            S_SCAN: begin
                mem_raddr = (r_proc == r_last) ? r_proc : r_proc + AW'(1);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    fba_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .WB    (WB)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    fba_word_eval u_eval (
        .i_data (mem_rdata),
        .i_mask (eval_mask),
        .i_want (r_want),
        .o_eval (ev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr_ptr <= '0;
            r_out_valid <= 1'b0;
            r_bits <= fba_pkg::BITS_IN_USE_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_bits <= i_cfg_data;
            end
            if (m_acc && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_ptr <= r_clr_ptr + AW'(1);
                    if (r_clr_ptr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        r_op <= in_op;
                        r_word <= in_word;
                        r_bit <= in_idx[LB-1:0];
                        r_range <= in_range;
                        r_proc <= '0;
                        r_last <= last_word;
                        r_last_mask <= last_mask;
                        r_lim <= CW'(lim32);
                        r_want <= (in_op == fba_pkg::OP_FIND_SET) ||
                                  (in_op == fba_pkg::OP_COUNT_SET);
                        r_bv <= 1'b0;
                        r_found <= 1'b0;
                        r_pos <= '0;
                        r_cnt <= '0;
                        case (in_op)
                            fba_pkg::OP_SET, fba_pkg::OP_CLEAR, fba_pkg::OP_TEST: begin
                                r_state <= S_MOD;
                            end
                            fba_pkg::OP_FIND_FREE, fba_pkg::OP_FIND_SET,
                            fba_pkg::OP_COUNT_FREE, fba_pkg::OP_COUNT_SET: begin
                                r_state <= (lim32 == 32'd0) ? S_DONE : S_SCAN;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_MOD: begin
                    if (r_op == fba_pkg::OP_TEST) begin
                        r_bv <= r_range && mem_rdata[r_bit];
                    end
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    if (is_find) begin
                        if (ev.hit) begin
                            r_found <= 1'b1;
                            r_pos <= fba_pkg::IDX_BITS'(hit_pos);
                        end
                    end else begin
                        r_cnt <= r_cnt + CW'(ev.ones);
                    end
                    if ((is_find && ev.hit) || (r_proc == r_last)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_proc <= r_proc + AW'(1);
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data <= {5'd0, fba_pkg::CNT_BITS'(r_cnt), r_pos, r_found, r_bv};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `FBA_ASSERT(a_scan_in_bounds, i_clk, i_rst_n, (r_state != S_SCAN) || (r_proc <= r_last))
    `FBA_ASSERT_IMPL(a_accept_leaves_idle, i_clk, i_rst_n, s_acc, r_state != S_IDLE)
    `FBA_ASSERT(a_count_in_limit, i_clk, i_rst_n, (r_state != S_DONE) || (r_cnt <= r_lim))
    `FBA_ASSERT(a_pos_in_limit, i_clk, i_rst_n, !((r_state == S_DONE) && r_found) || (32'(r_pos) < 32'(r_lim)))

endmodule

// ===== rtl/fba_mem.sv =====
// Bitmap word store: one write port and one registered read port.
// Depends on nothing; the top level sets its depth and widths.
`timescale 1ns / 1ps
module fba_mem #(
    parameter int DEPTH = 64,
    parameter int AW = 6,
    parameter int WB = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [WB-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [WB-1:0] o_rdata
);

    logic [WB-1:0] r_mem [DEPTH];
    logic [WB-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fba_word_eval.sv =====
// Evaluates one bitmap word: lowest matching bit and number of matching bits.
// Depends on fba_pkg for the word geometry and the result struct.
`timescale 1ns / 1ps
module fba_word_eval (
    input  logic [fba_pkg::WORD_BITS-1:0] i_data,
    input  logic [fba_pkg::WORD_BITS-1:0] i_mask,
    input  logic                          i_want,
    output fba_pkg::t_eval                o_eval
);

    always_comb begin
        logic [fba_pkg::WORD_BITS-1:0] m;
        logic [fba_pkg::BYTE_BITS-1:0] byte_v;
        logic [3:0] bcnt [fba_pkg::BYTES_PER_WORD];
        logic [2:0] blow [fba_pkg::BYTES_PER_WORD];
        logic [fba_pkg::BYTES_PER_WORD-1:0] bnz;
        logic [6:0] total;
        logic [5:0] lsb;

        m = (i_want ? i_data : ~i_data) & i_mask;
        for (int b = 0; b < fba_pkg::BYTES_PER_WORD; b++) begin
            byte_v = m[b*fba_pkg::BYTE_BITS +: fba_pkg::BYTE_BITS];
            bcnt[b] = 4'd0;
            blow[b] = 3'd0;
            for (int j = 0; j < fba_pkg::BYTE_BITS; j++) begin
                bcnt[b] = bcnt[b] + 4'(byte_v[j]);
            end
            for (int j = fba_pkg::BYTE_BITS - 1; j >= 0; j--) begin
                if (byte_v[j]) begin
                    blow[b] = 3'(j);
                end
            end
            bnz[b] = |byte_v;
        end
        total = 7'd0;
        lsb = 6'd0;
        for (int b = 0; b < fba_pkg::BYTES_PER_WORD; b++) begin
            total = total + 7'(bcnt[b]);
        end
        for (int b = fba_pkg::BYTES_PER_WORD - 1; b >= 0; b--) begin
            if (bnz[b]) begin
                lsb = {3'(b), blow[b]};
            end
        end
        o_eval.hit = |bnz;
        o_eval.lsb = lsb;
        o_eval.ones = total;
    end

endmodule
